@@ rtl/ssac_pkg.sv @@
// shared constants and types for the syn scan address counter
`timescale 1ns / 1ps
package ssac_pkg;

   localparam int TableEntries = 256;
   localparam int MaxAddrs     = 64;
   localparam int SlotW        = $clog2(TableEntries);
   localparam int VidxW        = $clog2(MaxAddrs);
   localparam int CountW       = 7;
   localparam int VaddrW       = SlotW + VidxW;

   localparam logic [7:0]  ProtoTcp     = 8'd6;
   localparam logic [7:0]  FlagSynOnly  = 8'd2;
   localparam logic [31:0] SinglePacket = 32'd1;

   localparam logic [CountW-1:0] ThrMax    = CountW'(MaxAddrs);
   localparam logic [CountW-1:0] ThrReset  = 7'd50;
   localparam logic [15:0]       IdleReset = 16'd300;
   localparam logic [15:0]       PintReset = 16'd60;

   // register indexes on the csr port
   localparam logic [1:0] RegAddrThreshold = 2'd0;
   localparam logic [1:0] RegIdleLimit     = 2'd1;
   localparam logic [1:0] RegPruneInterval = 2'd2;

   // result status codes
   localparam logic StatusAlert = 1'b0;
   localparam logic StatusFull  = 1'b1;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [47:0]       key;
      logic [CountW-1:0] count;
      logic [63:0]       first_seen;
      logic [63:0]       last_seen;
      logic [31:0]       touched;
   } entry_rec_type;

endpackage

@@ rtl/syn_scan_address_counter_core.sv @@
// top level: sequencer, valid bits and csr registers of the syn scan counter
//
// Usage: present a flow record on the req_ ports with start high while busy is
// low; the record is taken at that edge. Records that are not IPv4 are dropped
// at once and busy stays low. Any other record makes busy high until its work is
// done. Configuration beats on the csr_ channel are always taken (csr_ready is
// high) and must only be sent while busy is low.
// Results come on the rsp_ ports for exactly one cycle marked by rsp_valid: a
// scan alert (status 0) or a table full drop (status 1), at most one per record.
// The receiver cannot stall; every strobe must be taken.
// Sequence: the key lookup walks every entry of the entry memory with a read and
// a compare state per entry, the duplicate check walks the stored destinations
// in the same way until a match or the last one, then the entry is updated. A
// prune pass, when due, walks the entry memory again, one entry at a time. A
// non-qualifying IPv4 record goes straight to the prune check. The single entry
// memory read port is why each walk takes one entry at a time.
// Reset: clears all valid bits, last prune time, and loads register defaults.
`timescale 1ns / 1ps
module syn_scan_address_counter_core
   import ssac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_both_ipv4,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_dst_port_num,
   input  logic [31:0] req_packet_count,
   input  logic [7:0]  req_ip_protocol,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [63:0] req_flow_first_time,
   input  logic [63:0] req_flow_last_time,
   input  logic [31:0] req_now_seconds,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [31:0] rsp_alert_src_addr,
   output logic [15:0] rsp_alert_dst_port,
   output logic [63:0] rsp_alert_first_time,
   output logic [63:0] rsp_alert_last_time,
   output logic [6:0]  rsp_alert_addr_count,
   output logic [31:0] rsp_victim0,
   output logic [31:0] rsp_victim1,
   output logic [31:0] rsp_victim2,
   output logic [31:0] rsp_victim3
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_END, ST_ENT_RD, ST_ENT_CMP,
      ST_DUP_RD, ST_DUP_CMP, ST_UPDATE, ST_PRUNE_CHK, ST_PRUNE_RD, ST_PRUNE_CMP
   } state_type;

   localparam logic [SlotW-1:0] LastSlot = SlotW'(TableEntries - 1);

   state_type         state_ff;
   logic [SlotW-1:0]  idx_ff, slot_ff, free_ff;
   logic              found_ff, free_found_ff, seen_ff;
   logic [CountW-1:0] cnt_ff;
   logic [VidxW-1:0]  vidx_ff;
   logic [63:0]       first_ff, last_ff;
   logic [31:0]       vict_ff [4];
   logic [TableEntries-1:0] valid_ff;
   logic [31:0]       last_prune_ff;
   logic [CountW-1:0] thr_ff;
   logic [15:0]       idle_ff, pint_ff;

   // latched record
   logic [31:0] src_ff, dst_ff, now_ff;
   logic [15:0] port_ff;
   logic [63:0] tfirst_ff, tlast_ff;

   // registered result
   logic        rsp_valid_ff, rsp_status_ff;
   logic [31:0] rsp_src_ff;
   logic [15:0] rsp_port_ff;
   logic [63:0] rsp_first_ff, rsp_last_ff;
   logic [6:0]  rsp_count_ff;
   logic [31:0] rsp_vict_ff [4];

   // memory ports
   entry_rec_type     ent_rd, ent_wr;
   logic              ent_wr_en;
   logic [31:0]       vic_rd;
   logic              vic_wr_en;
   logic [VaddrW-1:0] vic_rd_addr, vic_wr_addr;

   // derived values
   logic [47:0]       key;
   logic              qualifies;
   logic [CountW-1:0] thr_sat, cnt_in;
   logic              insert;
   logic signed [32:0] prune_diff, idle_diff;
   logic [31:0]       vict_out [4];
   logic              full_drop, alert_hit, rsp_valid_in;

   assign key       = {src_ff, port_ff};
   assign qualifies = (req_packet_count == SinglePacket) && (req_ip_protocol == ProtoTcp)
                      && (req_tcp_flag_bits == FlagSynOnly);
   assign thr_sat   = (thr_ff > ThrMax) ? ThrMax : thr_ff;
   assign insert    = !seen_ff && (cnt_ff < ThrMax);
   assign cnt_in    = insert ? cnt_ff + 1'b1 : cnt_ff;
   assign prune_diff = $signed({1'b0, now_ff}) - $signed({1'b0, last_prune_ff});
   assign idle_diff  = $signed({1'b0, now_ff}) - $signed({1'b0, ent_rd.touched});

   // result strobe sources
   assign full_drop    = (state_ff == ST_SCAN_END) && !found_ff && !free_found_ff;
   assign alert_hit    = (state_ff == ST_UPDATE) && insert && (cnt_in >= thr_sat);
   assign rsp_valid_in = full_drop || alert_hit;

   // victims for an alert, including the address inserted now
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         vict_out[k] = (insert && (cnt_ff == CountW'(k))) ? dst_ff : vict_ff[k];
      end
   end

   // entry record write back
   always_comb begin
      ent_wr.key        = key;
      ent_wr.count      = cnt_in;
      ent_wr.first_seen = first_ff;
      ent_wr.last_seen  = last_ff;
      ent_wr.touched    = now_ff;
   end
   assign ent_wr_en   = (state_ff == ST_UPDATE);
   assign vic_wr_en   = (state_ff == ST_UPDATE) && insert;
   assign vic_wr_addr = {slot_ff, cnt_ff[VidxW-1:0]};
   assign vic_rd_addr = {slot_ff, vidx_ff};

   ssac_ram #(.DATA_W($bits(entry_rec_type)), .ADDR_W(SlotW)) u_entry_ram (
      .clock      (clock),
      .wr_en      (ent_wr_en),
      .wr_addr    (slot_ff),
      .wr_data    (ent_wr),
      .rd_addr    (idx_ff),
      .rd_data_ff (ent_rd)
   );

   ssac_ram #(.DATA_W(32), .ADDR_W(VaddrW)) u_victim_ram (
      .clock      (clock),
      .wr_en      (vic_wr_en),
      .wr_addr    (vic_wr_addr),
      .wr_data    (dst_ff),
      .rd_addr    (vic_rd_addr),
      .rd_data_ff (vic_rd)
   );

   // csr registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= ThrReset;
         idle_ff <= IdleReset;
         pint_ff <= PintReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegAddrThreshold: thr_ff  <= csr_wdata[CountW-1:0];
            RegIdleLimit:     idle_ff <= csr_wdata;
            RegPruneInterval: pint_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         last_prune_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  src_ff    <= req_src_addr;
                  dst_ff    <= req_dst_addr;
                  port_ff   <= req_dst_port_num;
                  tfirst_ff <= req_flow_first_time;
                  tlast_ff  <= req_flow_last_time;
                  now_ff    <= req_now_seconds;
                  idx_ff        <= '0;
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  if (req_both_ipv4) begin
                     state_ff <= qualifies ? ST_SCAN_RD : ST_PRUNE_CHK;
                  end
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CMP;
            ST_SCAN_CMP: begin
               if (valid_ff[idx_ff]) begin
                  if (ent_rd.key == key && !found_ff) begin
                     found_ff <= 1'b1;
                     slot_ff  <= idx_ff;
                  end
               end else if (!free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_ff       <= idx_ff;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff == LastSlot) ? ST_SCAN_END : ST_SCAN_RD;
            end
            ST_SCAN_END: begin
               for (int k = 0; k < 4; k++) vict_ff[k] <= '0;
               seen_ff <= 1'b0;
               if (found_ff) begin
                  idx_ff   <= slot_ff;
                  state_ff <= ST_ENT_RD;
               end else if (free_found_ff) begin
                  slot_ff           <= free_ff;
                  valid_ff[free_ff] <= 1'b1;
                  cnt_ff            <= '0;
                  first_ff          <= tfirst_ff;
                  last_ff           <= tlast_ff;
                  state_ff          <= ST_UPDATE;
               end else begin
                  rsp_status_ff <= StatusFull;
                  rsp_src_ff    <= src_ff;
                  rsp_port_ff   <= port_ff;
                  rsp_first_ff  <= tfirst_ff;
                  rsp_last_ff   <= tlast_ff;
                  rsp_count_ff  <= '0;
                  for (int k = 0; k < 4; k++) rsp_vict_ff[k] <= '0;
                  state_ff <= ST_PRUNE_CHK;
               end
            end
            ST_ENT_RD: state_ff <= ST_ENT_CMP;
            ST_ENT_CMP: begin
               cnt_ff  <= ent_rd.count;
               vidx_ff <= '0;
               if (ent_rd.count == '0) begin
                  first_ff <= tfirst_ff;
                  last_ff  <= tlast_ff;
                  state_ff <= ST_UPDATE;
               end else begin
                  first_ff <= (ent_rd.first_seen > tfirst_ff) ? tfirst_ff : ent_rd.first_seen;
                  last_ff  <= (ent_rd.last_seen < tlast_ff) ? tlast_ff : ent_rd.last_seen;
                  state_ff <= ST_DUP_RD;
               end
            end
            ST_DUP_RD: state_ff <= ST_DUP_CMP;
            ST_DUP_CMP: begin
               if (vidx_ff < VidxW'(4)) vict_ff[vidx_ff[1:0]] <= vic_rd;
               if (vic_rd == dst_ff) begin
                  seen_ff  <= 1'b1;
                  state_ff <= ST_UPDATE;
               end else if ({1'b0, vidx_ff} == cnt_ff - 1'b1) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  vidx_ff  <= vidx_ff + 1'b1;
                  state_ff <= ST_DUP_RD;
               end
            end
            ST_UPDATE: begin
               if (alert_hit) begin
                  valid_ff[slot_ff] <= 1'b0;
                  rsp_status_ff <= StatusAlert;
                  rsp_src_ff    <= src_ff;
                  rsp_port_ff   <= port_ff;
                  rsp_first_ff  <= first_ff;
                  rsp_last_ff   <= last_ff;
                  rsp_count_ff  <= cnt_in;
                  for (int k = 0; k < 4; k++) rsp_vict_ff[k] <= vict_out[k];
               end
               state_ff <= ST_PRUNE_CHK;
            end
            ST_PRUNE_CHK: begin
               idx_ff <= '0;
               if (prune_diff > $signed({17'b0, pint_ff})) begin
                  last_prune_ff <= now_ff;
                  state_ff      <= ST_PRUNE_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PRUNE_RD: state_ff <= ST_PRUNE_CMP;
            ST_PRUNE_CMP: begin
               if (valid_ff[idx_ff] && idle_diff > $signed({17'b0, idle_ff})) begin
                  valid_ff[idx_ff] <= 1'b0;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff == LastSlot) ? ST_IDLE : ST_PRUNE_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_alert_src_addr   = rsp_src_ff;
   assign rsp_alert_dst_port   = rsp_port_ff;
   assign rsp_alert_first_time = rsp_first_ff;
   assign rsp_alert_last_time  = rsp_last_ff;
   assign rsp_alert_addr_count = rsp_count_ff;
   assign rsp_victim0          = rsp_vict_ff[0];
   assign rsp_victim1          = rsp_vict_ff[1];
   assign rsp_victim2          = rsp_vict_ff[2];
   assign rsp_victim3          = rsp_vict_ff[3];

`ifndef ASSERT_OFF
   // a result only comes while a record is in work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");

   // at most one result per record
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two result strobes in a row");

   // non ipv4 records leave the block idle
   a_non_ipv4: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_both_ipv4 |=> !busy) else $error("non ipv4 record taken");

   // an alert always carries a count
   a_alert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StatusAlert |-> rsp_alert_addr_count != '0)
      else $error("alert with zero count");
`endif

endmodule

@@ rtl/ssac_ram.sv @@
// simple dual port ram with registered read data
`timescale 1ns / 1ps
module ssac_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
